FILE: hdl/swt4_pkg.sv
// swt4_pkg: shared constants, request codes and controller/datapath structs
// for the skin weight top-4 collector; no dependencies
package swt4_pkg;

  // default geometry, handed down from the top level
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int SLOTS_DEF        = 4;

  // fixed field widths
  localparam int REQ_W     = 2;
  localparam int VID_W     = 10;
  localparam int BONE_IN_W = 8;
  localparam int BONE_W    = 9;
  localparam int WGT_W     = 16;
  localparam int CFG_W     = 11;
  localparam int OUT_SLOTS = 4;

  // bones at or above this count are dropped on add
  localparam int BONE_COUNT = 256;

  // Q1.15 one and the empty-slot marker
  localparam logic [WGT_W-1:0]  Q_ONE      = 16'h8000;
  localparam logic [BONE_W-1:0] EMPTY_BONE = 9'h1FF;

  // restoring divider: one quotient bit per step
  localparam int DIV_STEPS = 16;
  localparam int DCNT_W    = 4;
  localparam int FRAC_W    = 15;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic clr_start;
    logic clr_step;
    logic add_wr;
    logic sum_ld;
    logic div_ld;
    logic div_step;
    logic out_ld;
  } swt4_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic div_last;
  } swt4_sts_t;

endpackage

FILE: hdl/swt4_if.sv
// swt4_in_if / swt4_out_if: valid-ready channels for request and result beats
// depends on swt4_pkg for field widths
interface swt4_in_if;
  import swt4_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [VID_W-1:0]     vertex_id;
  logic [BONE_IN_W-1:0] bone_index;
  logic [WGT_W-1:0]     weight;
  modport source (output valid, req_type, vertex_id, bone_index, weight, input ready);
  modport sink   (input valid, req_type, vertex_id, bone_index, weight, output ready);
endinterface

interface swt4_out_if;
  import swt4_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [VID_W-1:0]         read_vertex;
  logic signed [BONE_W-1:0] slot0_bone;
  logic signed [BONE_W-1:0] slot1_bone;
  logic signed [BONE_W-1:0] slot2_bone;
  logic signed [BONE_W-1:0] slot3_bone;
  logic [WGT_W-1:0]         slot0_weight;
  logic [WGT_W-1:0]         slot1_weight;
  logic [WGT_W-1:0]         slot2_weight;
  logic [WGT_W-1:0]         slot3_weight;
  modport source (output valid, read_vertex, slot0_bone, slot1_bone, slot2_bone, slot3_bone,
                  slot0_weight, slot1_weight, slot2_weight, slot3_weight, input ready);
  modport sink   (input valid, read_vertex, slot0_bone, slot1_bone, slot2_bone, slot3_bone,
                  slot0_weight, slot1_weight, slot2_weight, slot3_weight, output ready);
endinterface

FILE: hdl/swt4_ram.sv
// swt4_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module swt4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

FILE: hdl/swt4_ctrl.sv
// swt4_ctrl: sequencing state machine for clear sweep, add, and read/normalize
// depends on swt4_pkg for request codes and command/status structs
module swt4_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [swt4_pkg::REQ_W-1:0]    in_req_type,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output swt4_pkg::swt4_cmd_t           cmd,
  input  swt4_pkg::swt4_sts_t           sts
);
  import swt4_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_SUM,
    ST_DLD,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (in_req_type)
            REQ_ADD:  state_nxt = ST_ADD;
            REQ_READ: state_nxt = ST_SUM;
            REQ_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_nxt     = ST_CLEAR;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        cmd.add_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SUM: begin
        cmd.sum_ld = 1'b1;
        state_nxt  = ST_DLD;
      end
      ST_DLD: begin
        cmd.div_ld = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/swt4_dp.sv
// swt4_dp: slot table RAM, add slot selection, weight sum and four restoring
// dividers for normalization; depends on swt4_pkg and swt4_ram
module swt4_dp #(
  parameter int MAX_VERTICES     = swt4_pkg::MAX_VERTICES_DEF,
  parameter int SLOTS_PER_VERTEX = swt4_pkg::SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  swt4_pkg::swt4_cmd_t               cmd,
  output swt4_pkg::swt4_sts_t               sts,
  input  logic                              cfg_we,
  input  logic [swt4_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [swt4_pkg::VID_W-1:0]        in_vertex_id,
  input  logic [swt4_pkg::BONE_IN_W-1:0]    in_bone_index,
  input  logic [swt4_pkg::WGT_W-1:0]        in_weight,
  output logic [swt4_pkg::VID_W-1:0]        out_read_vertex,
  output logic [swt4_pkg::BONE_W-1:0]       out_bone   [swt4_pkg::OUT_SLOTS],
  output logic [swt4_pkg::WGT_W-1:0]        out_weight [swt4_pkg::OUT_SLOTS]
);
  import swt4_pkg::*;

  localparam int AW     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int SLOT_W = BONE_W + WGT_W;
  localparam int ROW_W  = SLOTS_PER_VERTEX * SLOT_W;
  localparam int SI_W   = (SLOTS_PER_VERTEX > 1) ? $clog2(SLOTS_PER_VERTEX) : 1;
  localparam int SUM_W  = WGT_W + $clog2(SLOTS_PER_VERTEX + 1);
  localparam int NUM_W  = SUM_W + WGT_W;

  logic [CFG_W-1:0]     vcount_r;
  logic [AW-1:0]        clr_cnt_r;
  logic [DCNT_W-1:0]    dcnt_r;
  logic [VID_W-1:0]     vid_r;
  logic [BONE_IN_W-1:0] bone_r;
  logic [WGT_W-1:0]     wgt_r;
  logic [SUM_W-1:0]     sum_r;
  logic [VID_W-1:0]     out_vid_r;

  logic [ROW_W-1:0]  rdata;
  logic [ROW_W-1:0]  add_row;
  logic [ROW_W-1:0]  empty_row;
  logic [ROW_W-1:0]  wdata;
  logic [AW-1:0]     waddr;
  logic              we;
  logic [BONE_W-1:0] rd_bone [SLOTS_PER_VERTEX];
  logic [WGT_W-1:0]  rd_wgt  [SLOTS_PER_VERTEX];
  logic [SUM_W-1:0]  rd_sum;
  logic              in_range;
  logic              bone_ok;
  logic              found;
  logic [SI_W-1:0]   free_idx;
  logic [SI_W-1:0]   min_idx;
  logic [WGT_W-1:0]  min_w;
  logic [SI_W-1:0]   tgt;
  logic              add_hit;

  // slot table, one row per vertex
  swt4_ram #(.WIDTH(ROW_W), .DEPTH(MAX_VERTICES)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (AW'(in_vertex_id)),
    .rdata_r (rdata)
  );

  // unpack the row read back
  for (genvar s = 0; s < SLOTS_PER_VERTEX; s++) begin : g_unpack
    assign rd_bone[s] = rdata[s*SLOT_W +: BONE_W];
    assign rd_wgt[s]  = rdata[s*SLOT_W+BONE_W +: WGT_W];
  end

  assign in_range = ({1'b0, vid_r} < vcount_r) && (32'(vid_r) < MAX_VERTICES);
  assign bone_ok  = 32'(bone_r) < BONE_COUNT;

  // add: lowest empty slot, else first minimum
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int s = SLOTS_PER_VERTEX - 1; s >= 0; s--) begin
      if (rd_bone[s] == EMPTY_BONE) begin
        found    = 1'b1;
        free_idx = SI_W'(s);
      end
    end
    min_idx = '0;
    min_w   = rd_wgt[0];
    for (int s = 1; s < SLOTS_PER_VERTEX; s++) begin
      if (rd_wgt[s] < min_w) begin
        min_w   = rd_wgt[s];
        min_idx = SI_W'(s);
      end
    end
    tgt     = found ? free_idx : min_idx;
    add_hit = in_range && bone_ok && (found || (wgt_r > min_w));
  end

  // updated row and cleared row
  always_comb begin
    add_row   = rdata;
    empty_row = '0;
    for (int s = 0; s < SLOTS_PER_VERTEX; s++) begin
      empty_row[s*SLOT_W +: BONE_W] = EMPTY_BONE;
      if (SI_W'(s) == tgt) begin
        add_row[s*SLOT_W +: BONE_W]       = BONE_W'(bone_r);
        add_row[s*SLOT_W+BONE_W +: WGT_W] = wgt_r;
      end
    end
  end

  // write port: clear sweep or add
  assign we    = cmd.clr_step | (cmd.add_wr & add_hit);
  assign waddr = cmd.clr_step ? clr_cnt_r : AW'(vid_r);
  assign wdata = cmd.clr_step ? empty_row : add_row;

  // sum of occupied weights
  always_comb begin
    rd_sum = '0;
    for (int s = 0; s < SLOTS_PER_VERTEX; s++) begin
      if (rd_bone[s] != EMPTY_BONE) begin
        rd_sum = rd_sum + SUM_W'(rd_wgt[s]);
      end
    end
  end

  assign sts.clr_last = (clr_cnt_r == AW'(MAX_VERTICES - 1));
  assign sts.div_last = (dcnt_r == DCNT_W'(DIV_STEPS - 1));

  // control counters and config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r  <= '0;
      clr_cnt_r <= '0;
      dcnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        vcount_r <= cfg_wdata;
      end
      if (cmd.clr_start) begin
        clr_cnt_r <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd.div_ld) begin
        dcnt_r <= '0;
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r + DCNT_W'(1);
      end
    end
  end

  // request capture, weight saturated to one
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      vid_r  <= in_vertex_id;
      bone_r <= in_bone_index;
      wgt_r  <= (in_weight > Q_ONE) ? Q_ONE : in_weight;
    end
    if (cmd.sum_ld) begin
      sum_r <= rd_sum;
    end
    if (cmd.out_ld) begin
      out_vid_r <= vid_r;
    end
  end

  assign out_read_vertex = out_vid_r;

  // per-slot lanes: capture, restoring divide, result register
  for (genvar s = 0; s < OUT_SLOTS; s++) begin : g_lane
    if (s < SLOTS_PER_VERTEX) begin : g_used
      logic              occ_r;
      logic [BONE_W-1:0] lb_r;
      logic [WGT_W-1:0]  lw_r;
      logic [SUM_W-1:0]  rem_r;
      logic [WGT_W-1:0]  sh_r;
      logic [BONE_W-1:0] ob_r;
      logic [WGT_W-1:0]  ow_r;
      logic [NUM_W-1:0]  num;
      logic [SUM_W:0]    trial;
      logic              ge;

      assign num   = NUM_W'({lw_r, {FRAC_W{1'b0}}}) + NUM_W'(sum_r >> 1);
      assign trial = {rem_r, sh_r[WGT_W-1]};
      assign ge    = trial >= {1'b0, sum_r};

      always_ff @(posedge clk) begin
        if (cmd.sum_ld) begin
          occ_r <= in_range && (rd_bone[s] != EMPTY_BONE);
          lb_r  <= rd_bone[s];
          lw_r  <= rd_wgt[s];
        end
        if (cmd.div_ld) begin
          rem_r <= num[NUM_W-1:WGT_W];
          sh_r  <= num[WGT_W-1:0];
        end else if (cmd.div_step) begin
          rem_r <= ge ? SUM_W'(trial - {1'b0, sum_r}) : trial[SUM_W-1:0];
          sh_r  <= {sh_r[WGT_W-2:0], ge};
        end
        if (cmd.out_ld) begin
          ob_r <= occ_r ? lb_r : EMPTY_BONE;
          ow_r <= !occ_r ? '0 : ((sum_r == '0) ? lw_r : sh_r);
        end
      end

      assign out_bone[s]   = ob_r;
      assign out_weight[s] = ow_r;
    end else begin : g_unused
      assign out_bone[s]   = EMPTY_BONE;
      assign out_weight[s] = '0;
    end
  end

endmodule

FILE: hdl/skin_weight_top4_collector_unit.sv
// skin_weight_top4_collector_unit: top level joining controller and datapath
// depends on swt4_pkg, swt4_if, swt4_ctrl, swt4_dp (and swt4_ram below it)
//
// Keeps up to SLOTS_PER_VERTEX (bone, Q1.15 weight) slots per vertex in one
// RAM row per vertex and takes one request beat at a time. An add reads the
// RAM row, then writes it back. A read passes through row read, sum, divider
// load, the four restoring dividers (one quotient bit per cycle), then the
// output register, loaded once the previous result beat is taken, before its
// result beat is offered. A clear, and reset itself, sweeps the table one row
// per cycle over all MAX_VERTICES rows (1024 by default), during which no
// request is taken; vertex_count writes are taken at any time. Unused request
// code 3 is taken and gives no result.
module skin_weight_top4_collector_unit #(
  parameter int MAX_VERTICES     = swt4_pkg::MAX_VERTICES_DEF,
  parameter int SLOTS_PER_VERTEX = swt4_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  swt4_in_if.sink                    in_ch,
  swt4_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [swt4_pkg::CFG_W-1:0] cfg_wdata
);
  import swt4_pkg::*;

  swt4_cmd_t         cmd;
  swt4_sts_t         sts;
  logic [BONE_W-1:0] obone [OUT_SLOTS];
  logic [WGT_W-1:0]  owgt  [OUT_SLOTS];

  // sequencing
  swt4_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  // table and arithmetic
  swt4_dp #(
    .MAX_VERTICES     (MAX_VERTICES),
    .SLOTS_PER_VERTEX (SLOTS_PER_VERTEX)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_vertex_id    (in_ch.vertex_id),
    .in_bone_index   (in_ch.bone_index),
    .in_weight       (in_ch.weight),
    .out_read_vertex (out_ch.read_vertex),
    .out_bone        (obone),
    .out_weight      (owgt)
  );

  // result beat fields
  assign out_ch.slot0_bone   = $signed(obone[0]);
  assign out_ch.slot1_bone   = $signed(obone[1]);
  assign out_ch.slot2_bone   = $signed(obone[2]);
  assign out_ch.slot3_bone   = $signed(obone[3]);
  assign out_ch.slot0_weight = owgt[0];
  assign out_ch.slot1_weight = owgt[1];
  assign out_ch.slot2_weight = owgt[2];
  assign out_ch.slot3_weight = owgt[3];

  // a clear beat starts the sweep, so the next cycle takes nothing
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.req_type == REQ_CLEAR |=> !in_ch.ready)
    else $error("request taken right after clear");

  // a read beat starts the sum and divide sequence, so the next cycle takes nothing
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.req_type == REQ_READ |=> !in_ch.ready)
    else $error("request taken during read");

  // empty slots report zero weight
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.slot0_bone == -9'sd1 |-> out_ch.slot0_weight == '0)
    else $error("empty slot with nonzero weight");

endmodule
